// ===== hw/rtl/fbwa_pkg.sv =====
`timescale 1ns / 1ps

package fbwa_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 16;
    localparam int SIZE_IN_W = 16;
    localparam int ST_W      = 2;
    localparam int MODE_W    = 2;
    localparam int TOTAL_W   = 20;
    localparam int CNT_OUT_W = 5;

    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [OP_W-1:0] OP_EMPTY   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef struct packed {
        logic start;
        logic issue;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic tbl_empty;
        logic last_issue;
    } t_dp_stat;

endpackage

// ===== hw/rtl/fbwa_ctrl.sv =====
`timescale 1ns / 1ps

module fbwa_ctrl
    import fbwa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  t_dp_stat        i_dp_stat,
    output t_dp_cmd         o_dp_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       w_out_free;

    assign w_out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.start = 1'b1;
                    if (i_op == OP_ALLOC && !i_dp_stat.tbl_empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                o_dp_cmd.issue = 1'b1;
                if (i_dp_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_dp_cmd.exec = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_dp_cmd.exec) begin
            n_out_vld = 1'b1;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

endmodule

// ===== hw/rtl/fbwa_dp.sv =====
`timescale 1ns / 1ps

module fbwa_dp
    import fbwa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MODE_W-1:0]    i_cfg_wdata,
    input  logic [OP_W-1:0]      i_op,
    input  logic [ID_W-1:0]      i_block_id,
    input  logic [SIZE_IN_W-1:0] i_size,
    input  logic [ID_W-1:0]      i_process_id,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [ST_W-1:0]      o_status,
    output logic [ID_W-1:0]      o_granted_block,
    output logic [ID_W-1:0]      o_requester,
    output logic [TOTAL_W-1:0]   o_internal_waste,
    output logic [TOTAL_W-1:0]   o_external_free,
    output logic [CNT_OUT_W-1:0] o_blocks_loaded
);

    localparam int SW    = (SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = IDX_W + SW;
    localparam int CW    = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int BW    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam int ENT_W = ID_W + SW;

    logic [ENT_W-1:0]      r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_used;
    logic [MAX_BLOCKS-1:0] n_used;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [TOTAL_W-1:0]    r_waste;
    logic [TOTAL_W-1:0]    n_waste;
    logic [SUM_W-1:0]      r_free;
    logic [SUM_W-1:0]      n_free;
    logic [SUM_W-1:0]      r_loaded;
    logic [SUM_W-1:0]      n_loaded;
    logic [MODE_W-1:0]     r_mode;

    logic [OP_W-1:0]       r_op;
    logic [SW-1:0]         r_req;
    logic [ID_W-1:0]       r_bid;
    logic [ID_W-1:0]       r_pid;

    logic [IDX_W-1:0]      r_scan_addr;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [ENT_W-1:0]      r_rd_data;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pick_idx;
    logic [SW-1:0]         r_pick_size;
    logic [ID_W-1:0]       r_pick_ident;

    logic [SW-1:0]         w_rd_size;
    logic [ID_W-1:0]       w_rd_ident;
    logic                  w_cand;
    logic                  w_take;
    logic                  w_full;
    logic                  w_write;
    logic [TOTAL_W:0]      w_waste_sum;
    logic [SW-1:0]         w_diff;
    logic [CW-1:0]         w_free_ext;
    logic [BW-1:0]         w_cnt_ext;
    logic [ST_W-1:0]       n_status;
    logic [ID_W-1:0]       n_granted;

    assign w_rd_size  = r_rd_data[SW-1:0];
    assign w_rd_ident = r_rd_data[SW +: ID_W];
    assign w_full     = (r_count == CNT_W'(MAX_BLOCKS));
    assign w_write    = i_cmd.exec && (r_op == OP_LOAD) && !w_full;

    assign w_cand = r_rd_vld && !r_used[r_rd_idx] && (w_rd_size >= r_req);
    assign w_take = w_cand && (!r_found
                    || (r_mode == MODE_BEST  && w_rd_size < r_pick_size)
                    || (r_mode == MODE_WORST && w_rd_size > r_pick_size));

    assign o_stat.tbl_empty  = (r_count == '0);
    assign o_stat.last_issue = ((CNT_W'(r_scan_addr) + CNT_W'(1)) == r_count);

    assign w_diff      = r_pick_size - r_req;
    assign w_waste_sum = {1'b0, r_waste} + (TOTAL_W + 1)'(w_diff);

    always_comb begin
        n_count   = r_count;
        n_used    = r_used;
        n_waste   = r_waste;
        n_free    = r_free;
        n_loaded  = r_loaded;
        n_status  = ST_DONE;
        n_granted = '0;
        case (r_op)
            OP_EMPTY: begin
                n_count  = '0;
                n_used   = '0;
                n_waste  = '0;
                n_free   = '0;
                n_loaded = '0;
            end
            OP_LOAD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_used[r_count[IDX_W-1:0]] = 1'b0;
                    n_count  = r_count + CNT_W'(1);
                    n_loaded = r_loaded + SUM_W'(r_req);
                    n_free   = r_free + SUM_W'(r_req);
                end
            end
            OP_RELEASE: begin
                n_used  = '0;
                n_waste = '0;
                n_free  = r_loaded;
            end
            OP_ALLOC: begin
                if (r_found) begin
                    n_used[r_pick_idx] = 1'b1;
                    n_granted = r_pick_ident;
                    n_waste   = w_waste_sum[TOTAL_W] ? TOTAL_MAX
                                                     : w_waste_sum[TOTAL_W-1:0];
                    n_free    = r_free - SUM_W'(r_pick_size);
                end else begin
                    n_status = ST_NOFIT;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign w_free_ext = CW'(n_free);
    assign w_cnt_ext  = BW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FIRST;
            r_used   <= '0;
            r_count  <= '0;
            r_waste  <= '0;
            r_free   <= '0;
            r_loaded <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_used   <= n_used;
                r_count  <= n_count;
                r_waste  <= n_waste;
                r_free   <= n_free;
                r_loaded <= n_loaded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op        <= i_op;
            r_req       <= i_size[SW-1:0];
            r_bid       <= i_block_id;
            r_pid       <= i_process_id;
            r_scan_addr <= '0;
        end else if (i_cmd.issue) begin
            r_scan_addr <= r_scan_addr + IDX_W'(1);
        end
        if (i_cmd.issue) begin
            r_rd_idx <= r_scan_addr;
        end
        if (w_take) begin
            r_pick_idx   <= r_rd_idx;
            r_pick_size  <= w_rd_size;
            r_pick_ident <= w_rd_ident;
        end
        if (i_cmd.exec) begin
            o_status         <= n_status;
            o_granted_block  <= n_granted;
            o_requester      <= r_pid;
            o_internal_waste <= n_waste;
            o_external_free  <= (w_free_ext > CW'(TOTAL_MAX)) ? TOTAL_MAX
                                                              : w_free_ext[TOTAL_W-1:0];
            o_blocks_loaded  <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_bid, r_req};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_scan_addr];
        end
    end

endmodule

// ===== hw/rtl/fit_policy_block_allocator_unit.sv =====
// Block table allocator with first, best and worst fit placement.
// Input channel: i_valid with o_stall; a transaction carries op, block id,
// size and process id. Output channel: o_valid with i_stall; one result
// transaction per input transaction, in order.
// The fit mode register is written through i_cfg_we and i_cfg_wdata; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. Writes take effect at the next clock edge.
// Empty, load and release pass from the idle state straight to the exec
// state. An allocate scans the loaded slots through the slot memory read
// port, one slot per cycle, then passes a drain state before the exec
// state; an allocate on an empty table skips the scan. The exec state
// writes the result register that presents the result.
// One transaction is processed at a time.
// The result register decouples the two channels: a new transaction is
// accepted while a result still waits, and processing finishes up to the
// result write, which waits until the receiver drops i_stall.
// Synchronous active low reset empties the table, clears all totals,
// selects first fit and drops o_valid.
`timescale 1ns / 1ps

module fit_policy_block_allocator_unit
    import fbwa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MODE_W-1:0]    i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [ID_W-1:0]      i_block_id,
    input  logic [SIZE_IN_W-1:0] i_size,
    input  logic [ID_W-1:0]      i_process_id,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ST_W-1:0]      o_status,
    output logic [ID_W-1:0]      o_granted_block,
    output logic [ID_W-1:0]      o_requester,
    output logic [TOTAL_W-1:0]   o_internal_waste,
    output logic [TOTAL_W-1:0]   o_external_free,
    output logic [CNT_OUT_W-1:0] o_blocks_loaded
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fbwa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_op      (i_op),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_dp_stat (w_stat),
        .o_dp_cmd  (w_cmd)
    );

    fbwa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_op             (i_op),
        .i_block_id       (i_block_id),
        .i_size           (i_size),
        .i_process_id     (i_process_id),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_status         (o_status),
        .o_granted_block  (o_granted_block),
        .o_requester      (o_requester),
        .o_internal_waste (o_internal_waste),
        .o_external_free  (o_external_free),
        .o_blocks_loaded  (o_blocks_loaded)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a transaction");

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> !(o_valid && i_stall))
        else $error("result written while the previous result is stalled");

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.exec))
        else $error("result valid without a completed transaction");

    a_scan_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.issue || w_cmd.exec) |-> o_stall)
        else $error("slot scan or commit outside of a transaction");

endmodule
